>>> sv/rle_video_frame_decoder_macros.svh
// Assertion macros for the run-length video frame decoder.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef RLE_VIDEO_FRAME_DECODER_MACROS_SVH
`define RLE_VIDEO_FRAME_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define RVFD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RVFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RVFD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define RVFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> sv/rvfd_pkg.sv
// Shared types and constants of the run-length video frame decoder.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none
package rvfd_pkg;
  localparam int ADDR_BITS = 22;

  typedef logic [7:0]  byte_t;
  typedef logic [21:0] addr_t;
  typedef logic [11:0] count_t;
  typedef logic [2:0]  plen_t;
  typedef logic [15:0] dim_t;

  localparam int FRAME_WIDTH_RST = 640;

  // parse phases
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_HDR   = 4'd1;
  localparam logic [3:0] PH_OP    = 4'd2;
  localparam logic [3:0] PH_LONG1 = 4'd3;
  localparam logic [3:0] PH_LONG2 = 4'd4;
  localparam logic [3:0] PH_LIT   = 4'd5;
  localparam logic [3:0] PH_PAT   = 4'd6;
  localparam logic [3:0] PH_B254  = 4'd7;
  localparam logic [3:0] PH_B255  = 4'd8;
  localparam logic [3:0] PH_MASK1 = 4'd9;
  localparam logic [3:0] PH_MASK2 = 4'd10;
  localparam logic [3:0] PH_PAL   = 4'd11;
  localparam logic [3:0] PH_COP   = 4'd12;
  localparam logic [3:0] PH_CLEN  = 4'd13;
  localparam logic [3:0] PH_NIB   = 4'd14;

  // pattern operand kinds
  localparam logic [1:0] KIND_RAW = 2'd0;
  localparam logic [1:0] KIND_LOW = 2'd1;
  localparam logic [1:0] KIND_NIB = 2'd2;

  // long opcodes
  localparam logic [3:0] LOP_LIT   = 4'd0;
  localparam logic [3:0] LOP_RUN1  = 4'd1;
  localparam logic [3:0] LOP_RUN2  = 4'd2;
  localparam logic [3:0] LOP_RUN4  = 4'd3;
  localparam logic [3:0] LOP_SKIP  = 4'd4;
  localparam logic [3:0] LOP_LINES = 4'd5;
  localparam logic [3:0] LOP_END   = 4'd15;

  // compact extended opcodes
  localparam logic [3:0] COP_NIB   = 4'd0;
  localparam logic [3:0] COP_LOW   = 4'd1;
  localparam logic [3:0] COP_RUN2  = 4'd2;
  localparam logic [3:0] COP_RUN4  = 4'd3;
  localparam logic [3:0] COP_SKIP  = 4'd4;
  localparam logic [3:0] COP_LINES = 4'd5;

  localparam logic [3:0] HDR_LAST = 4'd9;
endpackage
`default_nettype wire

>>> sv/rvfd_in_if.sv
// Input channel of the decoder: chunk bytes with a chunk start flag.
// Depends on rvfd_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rvfd_in_if;
  logic            valid;
  logic            ready;
  rvfd_pkg::byte_t data_byte;
  logic            chunk_start;
  modport source (output valid, output data_byte, output chunk_start, input ready);
  modport sink (input valid, input data_byte, input chunk_start, output ready);
endinterface
`default_nettype wire

>>> sv/rvfd_out_if.sv
// Result channel of the decoder: one run descriptor per transaction.
// Depends on rvfd_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rvfd_out_if;
  logic             valid;
  logic             ready;
  rvfd_pkg::addr_t  pixel_address;
  rvfd_pkg::count_t repeat_count;
  rvfd_pkg::plen_t  pattern_length;
  rvfd_pkg::byte_t  pixel_a;
  rvfd_pkg::byte_t  pixel_b;
  rvfd_pkg::byte_t  pixel_c;
  rvfd_pkg::byte_t  pixel_d;
  logic             frame_done;
  modport source (output valid, output pixel_address, output repeat_count,
                  output pattern_length, output pixel_a, output pixel_b,
                  output pixel_c, output pixel_d, output frame_done, input ready);
  modport sink (input valid, input pixel_address, input repeat_count,
                input pattern_length, input pixel_a, input pixel_b,
                input pixel_c, input pixel_d, input frame_done, output ready);
endinterface
`default_nettype wire

>>> sv/rle_video_frame_decoder.sv
// Run-length video frame decoder, top level.
// A byte's result is registered and offered in the cycle after its transaction.
// Throughput: one byte per cycle while the result channel is not stalled; the parse step
// sits between the state registers and the output register, the row address multiply before base_r.
// Reset (rst_n low, synchronous): parser idle, frame width 640, palette zero.
// Depends on rvfd_pkg, rvfd_in_if, rvfd_out_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "rle_video_frame_decoder_macros.svh"
module rle_video_frame_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  rvfd_in_if.sink         in_ch,
  rvfd_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  localparam int AB = rvfd_pkg::ADDR_BITS;

  logic [15:0] fw_r;
  logic [3:0]  hdr_r, hdr_nxt;
  logic [15:0] left_r, left_nxt, top_r, top_nxt, wid_r, wid_nxt, hgt_r, hgt_nxt;
  logic        ilace_r, ilace_nxt;
  logic [16:0] col_r, col_nxt;
  logic [17:0] row_r, row_nxt;
  logic [AB-1:0] base_r, base_nxt;
  logic [3:0]  phase_r, phase_nxt;
  logic [11:0] run_r, run_nxt;
  logic [7:0]  ops_r [4];
  logic [7:0]  ops_nxt [4];
  logic [15:0] mask_r, mask_nxt;
  logic [7:0]  cc_r [16];
  logic [7:0]  cc_nxt [16];
  logic [2:0]  need_r, need_nxt;
  logic [1:0]  have_r, have_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [3:0]  sub_r, sub_nxt;

  logic        out_valid_r;
  rvfd_pkg::addr_t  addr_r;
  rvfd_pkg::count_t cnt_r;
  rvfd_pkg::plen_t  len_r;
  logic [7:0]  pix_r [4];
  logic        done_r;

  logic        in_ready, acc;
  logic        res_valid, res_write, res_done;
  rvfd_pkg::addr_t  res_addr;
  logic [7:0]  em_pix [4];
  logic [11:0] em_cnt;
  logic [2:0]  em_n;

  assign in_ready = !out_valid_r || out_ch.ready;
  assign acc = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_comb begin
    logic [7:0]  b;
    logic [3:0]  ph;
    logic [3:0]  hc;
    logic [3:0]  hi, lo, lop;
    logic [11:0] llen;
    logic        em;
    logic        col_zero, col_wid, fin_top, fin_cmp, row_start, row_end, base_req;
    logic [15:0] skip;
    logic [12:0] row_inc;
    logic        sp;
    logic [11:0] sp_cnt;
    logic [2:0]  sp_need;
    logic [1:0]  sp_kind;
    logic [16:0] col_base, col1;
    logic [13:0] span;
    logic [17:0] row1, area_end;
    logic [2:0]  have1;
    logic [15:0] mask_tmp;
    logic        found;
    logic [18:0] r0, r1;
    logic [AB-1:0] prod;

    b = in_ch.data_byte;
    ph = in_ch.chunk_start ? rvfd_pkg::PH_HDR : phase_r;
    hc = in_ch.chunk_start ? 4'd0 : hdr_r;
    hi = b[7:4];
    lo = b[3:0];
    lop = ops_r[0][7:4];
    llen = {ops_r[0][3:0], b};

    hdr_nxt = hdr_r; left_nxt = left_r; top_nxt = top_r; wid_nxt = wid_r;
    hgt_nxt = hgt_r; ilace_nxt = ilace_r; phase_nxt = ph; run_nxt = run_r;
    ops_nxt = ops_r; mask_nxt = mask_r; cc_nxt = cc_r; need_nxt = need_r;
    have_nxt = have_r; kind_nxt = kind_r; sub_nxt = sub_r;

    em = 1'b0; em_cnt = '0; em_n = '0;
    for (int i = 0; i < 4; i++) em_pix[i] = '0;
    col_zero = 1'b0; col_wid = 1'b0; fin_top = 1'b0; fin_cmp = 1'b0;
    row_start = 1'b0; row_end = 1'b0; base_req = 1'b0;
    skip = '0; row_inc = '0;
    sp = 1'b0; sp_cnt = '0; sp_need = '0; sp_kind = rvfd_pkg::KIND_RAW;
    res_done = 1'b0;
    have1 = {1'b0, have_r} + 3'd1;
    mask_tmp = mask_r;
    found = 1'b0;
    area_end = {2'b00, top_r} + {2'b00, hgt_r};

    unique case (ph)
      rvfd_pkg::PH_HDR: begin
        case (hc)
          4'd0: left_nxt[15:8] = b;
          4'd1: left_nxt[7:0] = b;
          4'd2: top_nxt[15:8] = b;
          4'd3: top_nxt[7:0] = b;
          4'd4: wid_nxt[15:8] = b;
          4'd5: wid_nxt[7:0] = b;
          4'd6: hgt_nxt[15:8] = b;
          4'd7: hgt_nxt[7:0] = b;
          4'd8: ilace_nxt = (lo != 4'd1);
          default: ;
        endcase
        if (hc == rvfd_pkg::HDR_LAST) begin
          hdr_nxt = '0;
          col_zero = 1'b1;
          row_start = 1'b1;
          base_req = 1'b1;
          if (hgt_r == '0) begin
            phase_nxt = rvfd_pkg::PH_IDLE;
            res_done = 1'b1;
          end else begin
            phase_nxt = rvfd_pkg::PH_OP;
          end
        end else begin
          hdr_nxt = hc + 4'd1;
        end
      end
      rvfd_pkg::PH_OP: begin
        if (b == 8'd0) begin
          phase_nxt = rvfd_pkg::PH_LONG1;
        end else if (b < 8'd128) begin
          run_nxt = {4'd0, b};
          phase_nxt = rvfd_pkg::PH_LIT;
        end else if (b < 8'd254) begin
          sp = 1'b1; sp_cnt = 12'(9'd256 - {1'b0, b}); sp_need = 3'd1;
        end else if (b == 8'd254) begin
          phase_nxt = rvfd_pkg::PH_B254;
        end else begin
          phase_nxt = rvfd_pkg::PH_B255;
        end
      end
      rvfd_pkg::PH_LONG1: begin
        ops_nxt[0] = b;
        phase_nxt = rvfd_pkg::PH_LONG2;
      end
      rvfd_pkg::PH_LONG2: begin
        ops_nxt[1] = b;
        case (lop)
          rvfd_pkg::LOP_LIT: begin
            if (llen == '0) begin
              fin_top = 1'b1;
            end else begin
              run_nxt = llen;
              phase_nxt = rvfd_pkg::PH_LIT;
            end
          end
          rvfd_pkg::LOP_RUN1: begin sp = 1'b1; sp_cnt = llen; sp_need = 3'd1; end
          rvfd_pkg::LOP_RUN2: begin sp = 1'b1; sp_cnt = llen; sp_need = 3'd2; end
          rvfd_pkg::LOP_RUN4: begin sp = 1'b1; sp_cnt = llen; sp_need = 3'd4; end
          rvfd_pkg::LOP_SKIP: begin skip = {4'd0, llen}; fin_top = 1'b1; end
          rvfd_pkg::LOP_LINES: begin
            col_zero = 1'b1;
            row_inc = {1'b0, llen} + 13'd1;
            base_req = 1'b1;
            fin_top = 1'b1;
          end
          rvfd_pkg::LOP_END: begin
            col_zero = 1'b1;
            row_end = 1'b1;
            fin_top = 1'b1;
          end
          default: begin
            // undefined long opcode: single pixel of value 255
            em = 1'b1; em_cnt = 12'd1; em_n = 3'd1; em_pix[0] = 8'hFF;
            fin_top = 1'b1;
          end
        endcase
      end
      rvfd_pkg::PH_LIT: begin
        em = 1'b1; em_cnt = 12'd1; em_n = 3'd1; em_pix[0] = b;
        run_nxt = run_r - 12'd1;
        if (run_nxt == '0) fin_top = 1'b1;
      end
      rvfd_pkg::PH_PAT: begin
        ops_nxt[have_r] = b;
        if (have1 >= need_r) begin
          em = 1'b1;
          em_cnt = run_r;
          case (kind_r)
            rvfd_pkg::KIND_RAW: begin
              for (int i = 0; i < 4; i++)
                em_pix[i] = (3'(i) < need_r) ? ops_nxt[i] : 8'd0;
              em_n = need_r;
              fin_top = 1'b1;
            end
            rvfd_pkg::KIND_LOW: begin
              em_pix[0] = cc_r[ops_nxt[0][3:0]];
              em_n = 3'd1;
              fin_cmp = 1'b1;
            end
            default: begin
              em_pix[0] = cc_r[ops_nxt[0][7:4]];
              em_pix[1] = cc_r[ops_nxt[0][3:0]];
              if (need_r == 3'd2) begin
                em_pix[2] = cc_r[ops_nxt[1][7:4]];
                em_pix[3] = cc_r[ops_nxt[1][3:0]];
              end
              em_n = {need_r[1:0], 1'b0};
              fin_cmp = 1'b1;
            end
          endcase
        end else begin
          have_nxt = have1[1:0];
        end
      end
      rvfd_pkg::PH_B254: begin
        if (b != 8'd0) begin
          skip = {8'd0, b};
          fin_top = 1'b1;
        end else begin
          phase_nxt = rvfd_pkg::PH_MASK1;
        end
      end
      rvfd_pkg::PH_B255: begin
        sp = 1'b1;
        if (b < 8'd128) begin
          sp_cnt = {4'd0, b}; sp_need = 3'd2;
        end else begin
          sp_cnt = 12'(9'd256 - {1'b0, b}); sp_need = 3'd4;
        end
      end
      rvfd_pkg::PH_MASK1: begin
        mask_nxt = {b, 8'd0};
        phase_nxt = rvfd_pkg::PH_MASK2;
      end
      rvfd_pkg::PH_MASK2: begin
        mask_nxt = {mask_r[15:8], b};
        if (mask_nxt != '0) phase_nxt = rvfd_pkg::PH_PAL;
        else fin_cmp = 1'b1;
      end
      rvfd_pkg::PH_PAL: begin
        // load the lowest pending palette entry
        for (int i = 0; i < 16; i++) begin
          if (!found && mask_r[i]) begin
            found = 1'b1;
            cc_nxt[i] = b;
            mask_tmp[i] = 1'b0;
          end
        end
        mask_nxt = mask_tmp;
        if (mask_tmp == '0) fin_cmp = 1'b1;
      end
      rvfd_pkg::PH_COP: begin
        if (hi == 4'd0) begin
          sub_nxt = lo;
          phase_nxt = rvfd_pkg::PH_CLEN;
        end else if (hi < 4'd8) begin
          em = 1'b1; em_cnt = 12'd1; em_n = 3'd1; em_pix[0] = cc_r[lo];
          run_nxt = {8'd0, hi - 4'd1};
          if (run_nxt == '0) fin_cmp = 1'b1;
          else phase_nxt = rvfd_pkg::PH_NIB;
        end else if (hi < 4'd14) begin
          em = 1'b1; em_cnt = 12'(5'd16 - {1'b0, hi}); em_n = 3'd1;
          em_pix[0] = cc_r[lo];
          fin_cmp = 1'b1;
        end else if (hi == 4'd14) begin
          skip = {12'd0, lo};
          fin_cmp = 1'b1;
        end else if (lo < 4'd8) begin
          sp = 1'b1; sp_cnt = {8'd0, lo}; sp_need = 3'd1; sp_kind = rvfd_pkg::KIND_NIB;
        end else begin
          sp = 1'b1; sp_cnt = 12'(5'd16 - {1'b0, lo}); sp_need = 3'd2;
          sp_kind = rvfd_pkg::KIND_NIB;
        end
      end
      rvfd_pkg::PH_CLEN: begin
        case (sub_r)
          rvfd_pkg::COP_NIB: begin
            if (b == 8'd0) begin
              fin_cmp = 1'b1;
            end else begin
              run_nxt = {4'd0, b};
              phase_nxt = rvfd_pkg::PH_NIB;
            end
          end
          rvfd_pkg::COP_LOW: begin
            sp = 1'b1; sp_cnt = {4'd0, b}; sp_need = 3'd1; sp_kind = rvfd_pkg::KIND_LOW;
          end
          rvfd_pkg::COP_RUN2: begin
            sp = 1'b1; sp_cnt = {4'd0, b}; sp_need = 3'd1; sp_kind = rvfd_pkg::KIND_NIB;
          end
          rvfd_pkg::COP_RUN4: begin
            sp = 1'b1; sp_cnt = {4'd0, b}; sp_need = 3'd2; sp_kind = rvfd_pkg::KIND_NIB;
          end
          rvfd_pkg::COP_SKIP: begin skip = {8'd0, b}; fin_cmp = 1'b1; end
          rvfd_pkg::COP_LINES: begin
            col_wid = 1'b1;
            row_inc = {5'd0, b};
            fin_cmp = 1'b1;
          end
          default: fin_cmp = 1'b1;
        endcase
      end
      rvfd_pkg::PH_NIB: begin
        em = 1'b1; em_cnt = 12'd1;
        em_pix[0] = cc_r[hi];
        em_pix[1] = (run_r >= 12'd2) ? cc_r[lo] : 8'd0;
        em_n = (run_r >= 12'd2) ? 3'd2 : 3'd1;
        run_nxt = run_r - {9'd0, em_n};
        if (run_nxt == '0) fin_cmp = 1'b1;
      end
      default: ;
    endcase

    if (sp) begin
      run_nxt = sp_cnt;
      need_nxt = sp_need;
      have_nxt = '0;
      kind_nxt = sp_kind;
      phase_nxt = rvfd_pkg::PH_PAT;
    end

    res_write = em && (em_cnt != '0);
    res_addr = rvfd_pkg::addr_t'(base_r + AB'(col_r));

    // advance column and row
    col_base = col_zero ? 17'd0 : (col_wid ? {1'b0, wid_r} : col_r);
    case (em_n)
      3'd4: span = {em_cnt, 2'b00};
      3'd2: span = {1'b0, em_cnt, 1'b0};
      default: span = {2'b00, em_cnt};
    endcase
    if (!res_write) span = '0;
    col1 = col_base + {3'd0, span} + {1'b0, skip};
    if (row_start) row1 = {2'b00, top_r};
    else if (row_end) row1 = area_end;
    else row1 = row_r + {5'd0, row_inc};

    if (fin_cmp) begin
      if (col1 >= {1'b0, wid_r}) fin_top = 1'b1;
      else phase_nxt = rvfd_pkg::PH_COP;
    end
    if (fin_top) begin
      if (col1 >= {1'b0, wid_r}) begin
        col1 = '0;
        row1 = row1 + 18'd1;
        base_req = 1'b1;
      end
      if (row1 >= area_end) begin
        phase_nxt = rvfd_pkg::PH_IDLE;
        res_done = 1'b1;
      end else begin
        phase_nxt = rvfd_pkg::PH_OP;
      end
    end
    col_nxt = col1;
    row_nxt = row1;

    // row start address, interlaced rows fold back after the first field
    r0 = {row1, 1'b0} - {3'd0, top_r};
    r1 = {1'b0, row1};
    if (ilace_r) begin
      r1 = r0;
      if (r0 >= {1'b0, area_end})
        r1 = r0 - {3'd0, hgt_r} + {18'd0, !hgt_r[0]};
    end
    prod = AB'(r1) * AB'(fw_r);
    base_nxt = base_req ? (AB'(left_r) + prod) : base_r;

    res_valid = res_write || res_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 16'(rvfd_pkg::FRAME_WIDTH_RST);
      hdr_r <= '0; left_r <= '0; top_r <= '0; wid_r <= '0; hgt_r <= '0;
      ilace_r <= 1'b0; col_r <= '0; row_r <= '0; base_r <= '0;
      phase_r <= rvfd_pkg::PH_IDLE; run_r <= '0; mask_r <= '0;
      for (int i = 0; i < 4; i++) ops_r[i] <= '0;
      for (int i = 0; i < 16; i++) cc_r[i] <= '0;
      need_r <= '0; have_r <= '0; kind_r <= rvfd_pkg::KIND_RAW; sub_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) fw_r <= cfg_wdata;
      if (acc) begin
        hdr_r <= hdr_nxt; left_r <= left_nxt; top_r <= top_nxt; wid_r <= wid_nxt;
        hgt_r <= hgt_nxt; ilace_r <= ilace_nxt; col_r <= col_nxt; row_r <= row_nxt;
        base_r <= base_nxt; phase_r <= phase_nxt; run_r <= run_nxt;
        mask_r <= mask_nxt; ops_r <= ops_nxt; cc_r <= cc_nxt;
        need_r <= need_nxt; have_r <= have_nxt; kind_r <= kind_nxt; sub_r <= sub_nxt;
        out_valid_r <= res_valid;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, held while the transaction stalls
  always_ff @(posedge clk) begin
    if (acc) begin
      addr_r <= res_write ? res_addr : '0;
      cnt_r  <= res_write ? em_cnt : '0;
      len_r  <= res_write ? em_n : '0;
      for (int i = 0; i < 4; i++) pix_r[i] <= res_write ? em_pix[i] : 8'd0;
      done_r <= res_done;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.pixel_address  = addr_r;
  assign out_ch.repeat_count   = cnt_r;
  assign out_ch.pattern_length = len_r;
  assign out_ch.pixel_a        = pix_r[0];
  assign out_ch.pixel_b        = pix_r[1];
  assign out_ch.pixel_c        = pix_r[2];
  assign out_ch.pixel_d        = pix_r[3];
  assign out_ch.frame_done     = done_r;

  `RVFD_ASSERT_SAME(a_no_empty_result, clk, rst_n, out_valid_r, (len_r != '0) || done_r, "result without write or frame done")
  `RVFD_ASSERT_NEXT(a_idle_silent, clk, rst_n, acc && (phase_r == rvfd_pkg::PH_IDLE) && !in_ch.chunk_start, !out_valid_r, "idle byte produced a result")
  `RVFD_ASSERT_SAME(a_pat_count, clk, rst_n, phase_r == rvfd_pkg::PH_PAT, ({1'b0, have_r} < need_r), "pattern operand count overrun")
  `RVFD_ASSERT_SAME(a_done_idle, clk, rst_n, out_valid_r && done_r, phase_r == rvfd_pkg::PH_IDLE || phase_r == rvfd_pkg::PH_HDR, "frame done while still parsing")
endmodule
`default_nettype wire
